FILE: design/knst_pkg.sv
`timescale 1ns / 1ps

package knst_pkg;

   localparam int ID_W            = 16;
   localparam int DIST_W          = 32;
   localparam int RANK_W          = 4;
   localparam int K_W             = 5;
   localparam int MAX_NEIGHBORS_D = 16;
   localparam int ID_BITS_D       = 16;
   localparam logic [K_W-1:0] K_RESET = 5'd16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [ID_W-1:0]   candidate_id;
      logic [DIST_W-1:0] candidate_distance;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   neighbor_id;
      logic [DIST_W-1:0] neighbor_distance;
      logic [RANK_W-1:0] rank;
      logic              last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   // per-cycle command shared by every cell of the list
   typedef struct packed {
      logic insert;
      logic append;
      logic shift_out;
   } cell_ctl_type;

endpackage

FILE: design/knst_cell.sv
`timescale 1ns / 1ps

module knst_cell
   import knst_pkg::*;
#(
   parameter int IDX     = 0,
   parameter int FILL_W  = 5,
   parameter int ID_BITS = ID_BITS_D
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [FILL_W-1:0]  fill,
   input  logic [DIST_W-1:0]  cand_dist,
   input  logic [ID_BITS-1:0] cand_id,
   input  logic               left_gt,
   input  logic [DIST_W-1:0]  left_dist,
   input  logic [ID_BITS-1:0] left_id,
   input  logic [DIST_W-1:0]  right_dist,
   input  logic [ID_BITS-1:0] right_id,
   output logic               gt,
   output logic [DIST_W-1:0]  entry_dist,
   output logic [ID_BITS-1:0] id
);

   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic               occupied;
   logic               at_fill;

   assign occupied   = FILL_W'(IDX) < fill;
   assign at_fill    = FILL_W'(IDX) == fill;
   assign gt         = occupied && (dist_ff > cand_dist);
   assign entry_dist = dist_ff;
   assign id         = id_ff;

   always_comb begin
      dist_in = dist_ff;
      id_in   = id_ff;
      if (ctl.insert) begin
         if (left_gt) begin
            dist_in = left_dist;
            id_in   = left_id;
         end else if (gt || (ctl.append && at_fill)) begin
            // first strictly greater entry, or the tail slot on append
            dist_in = cand_dist;
            id_in   = cand_id;
         end
      end else if (ctl.shift_out) begin
         dist_in = right_dist;
         id_in   = right_id;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      id_ff   <= id_in;
   end

endmodule

FILE: design/k_nearest_sorted_tracker_core.sv
`timescale 1ns / 1ps
// insert beats are accepted back to back: every cell
// compares its entry against the candidate and shifts towards the tail at once
// a flush drains one beat per cycle unless rsp_stall holds it (through the
// output register, cell 0 first); inserts are held off until the drain ends
// synchronous reset empties the list and sets k to 16; entries are not cleared
module k_nearest_sorted_tracker_core
   import knst_pkg::*;
#(
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_D,
   parameter int ID_BITS       = ID_BITS_D
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [K_W-1:0] csr_data
);

   localparam int FILL_W = $clog2(MAX_NEIGHBORS + 1);
   localparam int CW     = (FILL_W > K_W) ? FILL_W : K_W;
   localparam int RW     = (FILL_W > RANK_W) ? FILL_W : RANK_W;

   state_type         state_ff, state_in;
   logic [K_W-1:0]    k_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] rank_ff, rank_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [DIST_W-1:0]  cell_dist [MAX_NEIGHBORS];
   logic [ID_BITS-1:0] cell_id   [MAX_NEIGHBORS];
   logic [MAX_NEIGHBORS-1:0] cell_gt;

   cell_ctl_type       ctl;
   logic               req_accept;
   logic               out_free;
   logic               placed;
   logic               append_en;
   logic               drain_last;
   logic [CW-1:0]      k_wide;
   logic [FILL_W-1:0]  k_eff;
   logic [FILL_W:0]    size_base;
   logic [FILL_W:0]    k_ext;
   logic [FILL_W:0]    rank_next;
   logic [RW-1:0]      rank_wide;
   logic [DIST_W-1:0]  cand_dist;
   logic [ID_BITS-1:0] cand_id;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign cand_dist = req_data.candidate_distance;
   assign cand_id   = ID_BITS'(req_data.candidate_id);

   // k above the list depth acts as the full depth
   assign k_wide = CW'(k_ff);
   assign k_eff  = (k_wide > CW'(MAX_NEIGHBORS)) ? FILL_W'(MAX_NEIGHBORS)
                                                 : FILL_W'(k_wide);
   assign k_ext  = {1'b0, k_eff};

   // entries are sorted, so the greater-than flags form a thermometer code
   assign placed    = |cell_gt;
   assign append_en = !placed && (fill_ff < k_eff);
   assign size_base = placed ? ({1'b0, fill_ff} + 1'b1) : {1'b0, fill_ff};

   assign rank_next  = {1'b0, rank_ff} + 1'b1;
   assign drain_last = rank_next == {1'b0, fill_ff};
   assign rank_wide  = RW'(rank_ff);

   always_comb begin
      ctl.insert    = req_accept && (req_data.opcode == OP_INSERT);
      ctl.append    = ctl.insert && append_en;
      ctl.shift_out = (state_ff == ST_DRAIN) && out_free;
   end

   generate
      for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
         logic               l_gt;
         logic [DIST_W-1:0]  l_dist, r_dist;
         logic [ID_BITS-1:0] l_id, r_id;

         if (i == 0) begin : g_head
            assign l_gt   = 1'b0;
            assign l_dist = '0;
            assign l_id   = '0;
         end else begin : g_mid
            assign l_gt   = cell_gt[i-1];
            assign l_dist = cell_dist[i-1];
            assign l_id   = cell_id[i-1];
         end

         if (i == MAX_NEIGHBORS - 1) begin : g_tail
            assign r_dist = '0;
            assign r_id   = '0;
         end else begin : g_body
            assign r_dist = cell_dist[i+1];
            assign r_id   = cell_id[i+1];
         end

         knst_cell #(
            .IDX     (i),
            .FILL_W  (FILL_W),
            .ID_BITS (ID_BITS)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .fill       (fill_ff),
            .cand_dist  (cand_dist),
            .cand_id    (cand_id),
            .left_gt    (l_gt),
            .left_dist  (l_dist),
            .left_id    (l_id),
            .right_dist (r_dist),
            .right_id   (r_id),
            .gt         (cell_gt[i]),
            .entry_dist (cell_dist[i]),
            .id         (cell_id[i])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rank_in      = rank_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.insert) begin
               if (size_base > k_ext) begin
                  fill_in = FILL_W'(size_base - 1'b1);
               end else if (!placed && (size_base < k_ext)) begin
                  fill_in = FILL_W'(size_base + 1'b1);
               end else begin
                  fill_in = FILL_W'(size_base);
               end
            end else if (req_accept && (fill_ff != '0)) begin
               state_in = ST_DRAIN;
               rank_in  = '0;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.neighbor_id       = ID_W'(cell_id[0]);
               rsp_data_in.neighbor_distance = cell_dist[0];
               rsp_data_in.rank              = rank_wide[RANK_W-1:0];
               rsp_data_in.last              = drain_last;
               rank_in                       = FILL_W'(rank_next);
               if (drain_last) begin
                  state_in = ST_IDLE;
                  fill_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= K_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            k_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import knst_pkg::*;

   localparam int LIMIT        = 600000;
   localparam int SETTLE       = 8;
   localparam int LIST_MAX     = MAX_NEIGHBORS_D;
   localparam int RANDOM_ITEMS = 400;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   req_type        req_data  = '0;
   logic           rsp_stall = 1'b0;
   logic           csr_valid = 1'b0;
   logic [K_W-1:0] csr_data  = '0;
   logic           req_stall;
   logic           rsp_valid;
   logic           csr_ready;
   rsp_type        rsp_data;

   // own copy of the sorted list and of k
   logic [K_W-1:0]    k_setting = K_RESET;
   logic [DIST_W-1:0] slot_dist [LIST_MAX];
   logic [ID_W-1:0]   slot_ident [LIST_MAX];
   int unsigned       held = 0;
   rsp_type           pending_neighbors [$];

   int  mismatches  = 0;
   int  cycle_count = 0;
   int  items_sent  = 0;
   int  burst_left  = 0;
   bit  no_idle     = 1'b0;
   int  stall_mode  = 0;
   int  stall_span  = 0;

   k_nearest_sorted_tracker_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatches < 50) $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   function automatic void update_neighbor_list(input req_type item);
      logic [DIST_W-1:0] nd [LIST_MAX+1];
      logic [ID_W-1:0]   ni [LIST_MAX+1];
      int unsigned       keff;
      int unsigned       size;
      int unsigned       pos;
      int unsigned       j;
      bit                placed;
      rsp_type           beat;
      keff = (k_setting > LIST_MAX) ? LIST_MAX : k_setting;
      if (item.opcode == OP_FLUSH) begin
         for (int i = 0; i < held; i++) begin
            beat.neighbor_id       = slot_ident[i];
            beat.neighbor_distance = slot_dist[i];
            beat.rank              = RANK_W'(i);
            beat.last              = (i + 1 == held);
            pending_neighbors      = {pending_neighbors, beat};
         end
         held = 0;
         return;
      end
      pos    = held;
      placed = 1'b0;
      for (int i = 0; i < held; i++) begin
         if (!placed && slot_dist[i] > item.candidate_distance) begin
            pos    = i;
            placed = 1'b1;
         end
      end
      for (int i = 0; i < held; i++) begin
         j     = (placed && i >= pos) ? i + 1 : i;
         nd[j] = slot_dist[i];
         ni[j] = slot_ident[i];
      end
      size = held;
      if (placed) begin
         nd[pos] = item.candidate_distance;
         ni[pos] = item.candidate_id;
         size    = held + 1;
      end
      // trims only one entry per insert, even when k was lowered further
      if (size > keff) begin
         size--;
      end else if (!placed && size < keff) begin
         nd[size] = item.candidate_distance;
         ni[size] = item.candidate_id;
         size++;
      end
      if (size > LIST_MAX) size = LIST_MAX;
      for (int i = 0; i < size; i++) begin
         slot_dist[i]  = nd[i];
         slot_ident[i] = ni[i];
      end
      held = size;
   endfunction

   // receiver stall pattern in one of four modes, each kept for a random span
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(4, 40);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= (stall_span % 4 != 0);
      endcase
   end

   always @(posedge clock) begin : check_beats
      rsp_type want;
      if (!reset && $isunknown(rsp_valid)) report_mismatch("rsp_valid unknown");
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_neighbors.size() == 0) begin
            report_mismatch($sformatf("unexpected beat id %h dist %h rank %0d last %b",
               rsp_data.neighbor_id, rsp_data.neighbor_distance, rsp_data.rank,
               rsp_data.last));
         end else begin
            want = pending_neighbors.pop_front();
            if (rsp_data.neighbor_id !== want.neighbor_id)
               report_mismatch($sformatf("neighbor_id %h, want %h",
                  rsp_data.neighbor_id, want.neighbor_id));
            if (rsp_data.neighbor_distance !== want.neighbor_distance)
               report_mismatch($sformatf("neighbor_distance %h, want %h",
                  rsp_data.neighbor_distance, want.neighbor_distance));
            if (rsp_data.rank !== want.rank)
               report_mismatch($sformatf("rank %0d, want %0d", rsp_data.rank, want.rank));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %b, want %b at rank %0d",
                  rsp_data.last, want.last, want.rank));
         end
      end
   end

   task automatic send_req(input req_type item);
      @(negedge clock);
      if (!no_idle) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = $urandom_range(1, 10);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      update_neighbor_list(item);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_neighbors.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_k(input logic [K_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      k_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_req(input logic op, input logic [ID_W-1:0] id,
                                        input logic [DIST_W-1:0] distance);
      req_type r;
      r.opcode             = op;
      r.candidate_id       = id;
      r.candidate_distance = distance;
      return r;
   endfunction

   function automatic logic [DIST_W-1:0] rand_distance();
      case ($urandom_range(0, 4))
         0: return DIST_W'($urandom_range(0, 7));     // dense ties
         1: return $urandom_range(0, 1) ? {DIST_W{1'b1}} : DIST_W'(0);
         2: return {16'($urandom_range(0, 3)), 16'($urandom())};
         default: return DIST_W'($urandom());
      endcase
   endfunction

   function automatic req_type rand_insert();
      return make_req(OP_INSERT, ID_W'($urandom_range(0, 65535)), rand_distance());
   endfunction

   function automatic req_type rand_flush();
      return make_req(OP_FLUSH, ID_W'($urandom_range(0, 65535)), DIST_W'($urandom()));
   endfunction

   // k as left by reset, list overfilled
   task automatic test_reset_k();
      repeat (20) send_req(rand_insert());
      send_req(rand_flush());
      wait_drained();
   endtask

   task automatic test_edges();
      send_req(make_req(OP_FLUSH, 16'hffff, 32'hffff_ffff));   // empty list
      send_req(make_req(OP_INSERT, 16'hffff, 32'hffff_ffff));
      send_req(make_req(OP_INSERT, 16'h0000, 32'h0000_0000));
      send_req(make_req(OP_INSERT, 16'h1234, 32'h0000_0000));  // tie keeps arrival order
      send_req(make_req(OP_INSERT, 16'h0005, 32'hffff_ffff));
      send_req(make_req(OP_INSERT, 16'h0007, 32'h0001_0000));
      send_req(make_req(OP_FLUSH, 16'h0000, 32'h0000_0000));
      wait_drained();
   endtask

   task automatic test_small_k();
      write_k(5'd1);
      send_req(make_req(OP_INSERT, 16'h0001, 32'd100));
      send_req(make_req(OP_INSERT, 16'h0002, 32'd50));
      send_req(make_req(OP_INSERT, 16'h0003, 32'd50));   // not nearer, list full
      send_req(make_req(OP_INSERT, 16'h0004, 32'd0));
      send_req(rand_flush());
      wait_drained();
      write_k(5'd0);
      send_req(make_req(OP_INSERT, 16'h0009, 32'd0));
      send_req(make_req(OP_INSERT, 16'h000a, 32'd3));
      send_req(rand_flush());
      wait_drained();
   endtask

   task automatic test_shrink_k();
      write_k(5'd16);
      for (int i = 0; i < 6; i++)
         send_req(make_req(OP_INSERT, ID_W'(i + 32), DIST_W'(i * 1000)));
      wait_drained();
      write_k(5'd2);
      send_req(make_req(OP_INSERT, 16'h00aa, 32'hffff_ffff));
      send_req(make_req(OP_INSERT, 16'h00bb, 32'h0000_0000));
      send_req(rand_flush());
      wait_drained();
   endtask

   task automatic test_random();
      logic [K_W-1:0] preset [8];
      logic [K_W-1:0] k_pick;
      int             phase;
      int             start;
      int unsigned    keff;
      int unsigned    n_ins;
      preset = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd17, 5'd2, 5'd8, 5'd5};
      phase  = 0;
      start  = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         k_pick  = (phase < 8) ? preset[phase] : K_W'($urandom_range(0, 31));
         write_k(k_pick);
         no_idle = ($urandom_range(0, 3) == 0);
         keff    = (k_pick > LIST_MAX) ? LIST_MAX : k_pick;
         repeat ($urandom_range(1, 4)) begin
            n_ins = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24)
                                                : $urandom_range(0, keff + 3);
            repeat (n_ins) begin
               // occasional stray flush breaks the sequence
               if ($urandom_range(0, 19) == 0) send_req(rand_flush());
               else send_req(rand_insert());
            end
            // sometimes no flush, so the next k meets a filled list
            if ($urandom_range(0, 4) != 0) send_req(rand_flush());
            if (phase == 0 || $urandom_range(0, 7) == 0) wait_drained();
         end
         wait_drained();
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_k();
      test_edges();
      test_small_k();
      test_shrink_k();
      test_random();
      wait_drained();
      if (pending_neighbors.size() != 0)
         report_mismatch($sformatf("%0d beats never arrived", pending_neighbors.size()));
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
